// ===== sv/pic_pkg.sv =====
// ============================================================================
// pic_pkg - shared types and constants for the PE checksum finisher
// Header offsets, signature bytes, status codes and inter-module structs.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package pic_pkg;

  // header layout
  localparam int HDR_BYTES    = 64;
  localparam int OPT_FROM_PE  = 24;
  localparam int CSUM_FROM_PE = 88;
  localparam int LK_READS     = 6;

  localparam logic [7:0]  CHAR_M     = 8'h4d;
  localparam logic [7:0]  CHAR_Z     = 8'h5a;
  localparam logic [15:0] MAGIC_PE32 = 16'h010b;
  localparam logic [15:0] MAGIC_PE64 = 16'h020b;

  localparam logic [2:0] LK_LAST_STEP = 3'd7;

  // result status codes
  localparam logic [2:0] STAT_NOT_PE  = 3'd0;
  localparam logic [2:0] STAT_NO_OPT  = 3'd1;
  localparam logic [2:0] STAT_TRUNC   = 3'd2;
  localparam logic [2:0] STAT_NO_SUM  = 3'd3;
  localparam logic [2:0] STAT_RECOMP  = 3'd4;

  typedef enum logic [0:0] {
    ST_RUN,
    ST_LOOK
  } pic_state_t;

  typedef struct packed {
    logic        en;
    logic [5:0]  addr;
    logic [7:0]  data;
  } pic_hdr_wr_t;

  typedef struct packed {
    logic        start;
    logic [31:0] at;
    logic        base_ok;
  } pic_lk_req_t;

  typedef struct packed {
    logic        done;
    logic        sig_ok;
    logic [15:0] magic;
  } pic_lk_res_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] new_checksum;
  } pic_res_t;

  // expected "PE\0\0" byte
  function automatic logic [7:0] pic_sig_byte(input logic [1:0] idx);
    logic [7:0] v;
    case (idx)
      2'd0:    v = 8'h50;
      2'd1:    v = 8'h45;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // distance from the PE offset for each lookup read
  function automatic logic [4:0] pic_lk_offset(input logic [2:0] idx);
    logic [4:0] v;
    case (idx)
      3'd0:    v = 5'd0;
      3'd1:    v = 5'd1;
      3'd2:    v = 5'd2;
      3'd3:    v = 5'd3;
      3'd4:    v = 5'(OPT_FROM_PE);
      3'd5:    v = 5'(OPT_FROM_PE + 1);
      default: v = 5'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== sv/pic_in_if.sv =====
// ============================================================================
// pic_in_if - byte stream channel
// valid/ready handshake carrying one file byte and its last marker.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface pic_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

`default_nettype wire

// ===== sv/pic_out_if.sv =====
// ============================================================================
// pic_out_if - checksum result channel
// valid/ready handshake carrying status and recomputed checksum.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface pic_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] new_checksum;

  modport source (output valid, output status, output new_checksum, input ready);
  modport sink   (input valid, input status, input new_checksum, output ready);
endinterface

`default_nettype wire

// ===== sv/pe_image_checksum_finisher.sv =====
// ============================================================================
// pe_image_checksum_finisher - PE image checksum recompute
// Streams a file byte by byte, validates the PE headers and returns the
// status and the folded word sum plus length on the last byte.
// ============================================================================
//
//  channel   dir   modport  payload                     transaction
//  --------  ----  -------  --------------------------  ------------------------
//  in_chan   in    sink     data_byte[7:0], is_last     one file byte
//  out_chan  out   source   status[2:0], new_checksum   one result per file
//
//  Cycles: one byte per cycle. After byte 63 of a file (and after every
//  wrap of the position counter past that point) the input stalls while
//  the header store is read, one read per cycle on its single port. A
//  result is registered when the last byte is accepted, or at the end of
//  that lookup when the file is exactly 64 bytes long.
//  Reset: synchronous, active low; clears all per-file state. The header
//  store is not cleared: it is always fully written before it is read.
//  Stalls: a two-entry output (register plus skid) lets input keep flowing
//  while a result waits; on the output side, input stops only when both entries are full.
//
`timescale 1ns / 1ps
`default_nettype none

module pe_image_checksum_finisher
  import pic_pkg::*;
#(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pic_in_if.sink     in_chan,
  pic_out_if.source  out_chan
);

  // wide enough for offset + 92 against any length without overflow
  localparam int CW = 34;

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------
  function automatic logic [16:0] fold16(input logic [17:0] s);
    return 17'(s[15:0]) + 17'(s[17:16]);
  endfunction

  // status and checksum from the post-byte file state
  function automatic pic_res_t finish(
    input logic [LENGTH_BITS-1:0] len,
    input logic [16:0]            sum,
    input logic [7:0]             pend,
    input logic                   ok,
    input logic [31:0]            at,
    input logic [15:0]            magic,
    input logic [31:0]            stored
  );
    logic [16:0]   s1;
    logic [16:0]   s2;
    logic [CW-1:0] lx;
    logic [CW-1:0] ax;
    logic [15:0]   mag;
    pic_res_t      r;
    // odd length: trailing byte still pending, added alone
    s1 = fold16(18'(sum) + 18'(len[0] ? pend : 8'h00));
    s2 = fold16(18'(s1));
    lx = CW'(len);
    ax = CW'(at);
    mag = '0;
    r.status       = STAT_NOT_PE;
    r.new_checksum = '0;
    if ((lx < CW'(HDR_BYTES)) || !ok || (ax + CW'(OPT_FROM_PE) > lx)) begin
      r.status = STAT_NOT_PE;
    end else begin
      // magic cut off by end of file reads as zero
      mag = (ax + CW'(OPT_FROM_PE + 2) <= lx) ? magic : 16'h0000;
      if ((mag != MAGIC_PE32) && (mag != MAGIC_PE64)) begin
        r.status = STAT_NO_OPT;
      end else if (ax + CW'(CSUM_FROM_PE + 4) > lx) begin
        r.status = STAT_TRUNC;
      end else if (stored == '0) begin
        r.status = STAT_NO_SUM;
      end else begin
        r.status       = STAT_RECOMP;
        r.new_checksum = 32'(CW'(s2) + lx);
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  pic_state_t              state_r, state_nxt;

  logic [LENGTH_BITS-1:0]  pos_r, pos_nxt;
  logic [7:0]              pend_r, pend_nxt;
  logic [16:0]             sum_r, sum_nxt;
  logic [31:0]             at_r, at_nxt;
  logic                    ok_r, ok_nxt;
  logic [15:0]             magic_r, magic_nxt;
  logic [31:0]             stored_r, stored_nxt;
  logic                    lk_last_r, lk_last_nxt;

  // fixed header bytes: MZ mark and the low three offset bytes
  logic [7:0]              h0_r, h1_r, h60_r, h61_r, h62_r;

  // output register plus skid entry
  logic                    out_valid_r, out_valid_nxt;
  pic_res_t                out_res_r, out_res_nxt;
  logic                    skid_valid_r, skid_valid_nxt;
  pic_res_t                skid_res_r, skid_res_nxt;

  logic                    in_ready;
  logic                    lk_start;
  logic                    acc;
  logic                    pop;
  logic                    push;
  pic_res_t                push_res;

  pic_hdr_wr_t             hdr_wr;
  pic_lk_req_t             lk_req;
  pic_lk_res_t             lk_res;

  // --------------------------------------------------------------------------
  // per-byte datapath
  // --------------------------------------------------------------------------
  logic [7:0]              b;
  logic                    last;
  logic [LENGTH_BITS-1:0]  pos_inc;
  logic                    p_in_hdr;
  logic                    p_hdr_end;
  logic [31:0]             at_new;
  logic [CW-1:0]           d_sig, d_mag, d_cs;
  logic                    sig_hit, mag_hit, cs_hit, skip;
  logic [16:0]             sum_step;
  logic [7:0]              pend_step;
  logic                    ok_step;
  logic [15:0]             magic_step;
  logic [31:0]             stored_step;

  assign b         = in_chan.data_byte;
  assign last      = in_chan.is_last;
  assign acc       = in_chan.valid && in_ready;
  assign pop       = out_valid_r && out_chan.ready;
  assign pos_inc   = pos_r + LENGTH_BITS'(1);
  assign p_in_hdr  = (pos_r[LENGTH_BITS-1:6] == '0);
  assign p_hdr_end = (pos_r == LENGTH_BITS'(HDR_BYTES - 1));
  assign at_new    = {b, h62_r, h61_r, h60_r};

  // distances from the signature, magic and checksum field; a sign bit of
  // zero with the low bits masked off means "inside that window"
  assign d_sig = CW'(pos_r) - CW'(at_r);
  assign d_mag = CW'(pos_r) - (CW'(at_r) + CW'(OPT_FROM_PE));
  assign d_cs  = CW'(pos_r) - (CW'(at_r) + CW'(CSUM_FROM_PE));

  assign sig_hit = !p_in_hdr && (d_sig[CW-1:2] == '0);
  assign mag_hit = !p_in_hdr && (d_mag[CW-1:1] == '0);
  assign cs_hit  = !p_in_hdr && (d_cs[CW-1:2] == '0);
  // the two checksum words count as zero when they start on an even byte
  assign skip    = cs_hit && pos_r[0] && d_cs[0];

  always_comb begin
    sum_step    = sum_r;
    pend_step   = pend_r;
    ok_step     = ok_r;
    magic_step  = magic_r;
    stored_step = stored_r;
    if (!pos_r[0]) begin
      pend_step = b;
    end else if (!skip) begin
      sum_step = fold16(18'(sum_r) + 18'({b, pend_r}));
    end
    if (sig_hit && (b != pic_sig_byte(d_sig[1:0]))) begin
      ok_step = 1'b0;
    end
    if (mag_hit) begin
      if (!d_mag[0]) begin
        magic_step[7:0] = b;
      end else begin
        magic_step[15:8] = b;
      end
    end
    if (cs_hit) begin
      case (d_cs[1:0])
        2'd0:    stored_step[7:0]   = b;
        2'd1:    stored_step[15:8]  = b;
        2'd2:    stored_step[23:16] = b;
        default: stored_step[31:24] = b;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // file state update
  // --------------------------------------------------------------------------
  always_comb begin
    pos_nxt     = pos_r;
    pend_nxt    = pend_r;
    sum_nxt     = sum_r;
    at_nxt      = at_r;
    ok_nxt      = ok_r;
    magic_nxt   = magic_r;
    stored_nxt  = stored_r;
    lk_last_nxt = lk_last_r;
    push        = 1'b0;
    push_res    = '0;
    if (acc) begin
      pos_nxt    = pos_inc;
      pend_nxt   = pend_step;
      sum_nxt    = sum_step;
      ok_nxt     = ok_step;
      magic_nxt  = magic_step;
      stored_nxt = stored_step;
      if (p_hdr_end) begin
        // header complete: offset known, lookup fills ok/magic
        at_nxt      = at_new;
        lk_last_nxt = last;
      end else if (last) begin
        push     = 1'b1;
        push_res = finish(pos_inc, sum_step, pend_step, ok_step, at_r,
                          magic_step, stored_step);
        pos_nxt    = '0;
        pend_nxt   = '0;
        sum_nxt    = '0;
        at_nxt     = '0;
        ok_nxt     = 1'b0;
        magic_nxt  = '0;
        stored_nxt = '0;
      end
    end else if (lk_res.done) begin
      ok_nxt      = lk_res.sig_ok;
      magic_nxt   = lk_res.magic;
      lk_last_nxt = 1'b0;
      if (lk_last_r) begin
        // file ended on byte 63
        push     = 1'b1;
        push_res = finish(pos_r, sum_r, pend_r, lk_res.sig_ok, at_r,
                          lk_res.magic, stored_r);
        pos_nxt    = '0;
        pend_nxt   = '0;
        sum_nxt    = '0;
        at_nxt     = '0;
        ok_nxt     = 1'b0;
        magic_nxt  = '0;
        stored_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      pend_r    <= '0;
      sum_r     <= '0;
      at_r      <= '0;
      ok_r      <= 1'b0;
      magic_r   <= '0;
      stored_r  <= '0;
      lk_last_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      pend_r    <= pend_nxt;
      sum_r     <= sum_nxt;
      at_r      <= at_nxt;
      ok_r      <= ok_nxt;
      magic_r   <= magic_nxt;
      stored_r  <= stored_nxt;
      lk_last_r <= lk_last_nxt;
    end
  end

  // fixed-position header bytes
  always_ff @(posedge clk) begin
    if (acc && p_in_hdr) begin
      case (pos_r[5:0])
        6'd0:    h0_r  <= b;
        6'd1:    h1_r  <= b;
        6'd60:   h60_r <= b;
        6'd61:   h61_r <= b;
        6'd62:   h62_r <= b;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // header store and lookup
  // --------------------------------------------------------------------------
  assign hdr_wr.en   = acc && p_in_hdr;
  assign hdr_wr.addr = pos_r[5:0];
  assign hdr_wr.data = b;

  assign lk_req.start   = lk_start;
  assign lk_req.at      = at_new;
  assign lk_req.base_ok = (h0_r == CHAR_M) && (h1_r == CHAR_Z) && (at_new != '0);

  pic_hdr_lookup u_lookup (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (hdr_wr),
    .req   (lk_req),
    .res   (lk_res)
  );

  // --------------------------------------------------------------------------
  // control FSM
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RUN: begin
        if (acc && p_hdr_end) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (lk_res.done) begin
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    lk_start = 1'b0;
    case (state_r)
      ST_RUN: begin
        in_ready = !skid_valid_r;
        lk_start = in_chan.valid && !skid_valid_r && p_hdr_end;
      end
      ST_LOOK: begin
        in_ready = 1'b0;
        lk_start = 1'b0;
      end
      default: begin
        in_ready = 1'b0;
        lk_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_chan.ready = in_ready;

  // --------------------------------------------------------------------------
  // output register and skid
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    skid_valid_nxt = skid_valid_r;
    skid_res_nxt   = skid_res_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end else if (push) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = push_res;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_res_r.status;
  assign out_chan.new_checksum = out_res_r.new_checksum;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_valid_r)
    else $error("result pushed with skid full");

  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while output is empty");

  a_done_in_look: assert property (@(posedge clk) disable iff (!rst_n)
    lk_res.done |-> (state_r == ST_LOOK))
    else $error("lookup done outside lookup state");

  a_start_enters: assert property (@(posedge clk) disable iff (!rst_n)
    lk_req.start |=> (state_r == ST_LOOK) && !in_ready)
    else $error("lookup start did not stall input");

endmodule

`default_nettype wire

// ===== sv/pic_hdr_lookup.sv =====
// ============================================================================
// pic_hdr_lookup - header store and signature/magic lookup
// Holds the first 64 bytes; after byte 63 reads the PE signature and magic
// bytes that fall inside the store, one read per cycle.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pic_hdr_lookup
  import pic_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire pic_hdr_wr_t wr,
  input  wire pic_lk_req_t req,
  output pic_lk_res_t      res
);

  logic [7:0]  mem [HDR_BYTES];
  logic [7:0]  rd_data_r;
  logic [5:0]  rd_addr;

  logic        act_r;
  logic [2:0]  cnt_r;
  logic [31:0] at_r;
  logic        ok_r;
  logic [15:0] magic_r;

  logic [2:0]  proc_idx;
  logic [32:0] q;
  logic        q_in_hdr;
  logic        proc_en;

  assign rd_addr  = at_r[5:0] + 6'(pic_lk_offset(cnt_r));
  assign proc_idx = cnt_r - 3'd1;
  assign q        = 33'(at_r) + 33'(pic_lk_offset(proc_idx));
  assign q_in_hdr = (q[32:6] == '0);
  assign proc_en  = act_r && (cnt_r != 3'd0) && (cnt_r <= 3'(LK_READS));

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      cnt_r <= '0;
    end else if (req.start) begin
      act_r <= 1'b1;
      cnt_r <= '0;
    end else if (act_r) begin
      if (cnt_r == LK_LAST_STEP) begin
        act_r <= 1'b0;
      end
      cnt_r <= cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      at_r    <= req.at;
      ok_r    <= req.base_ok;
      magic_r <= '0;
    end else if (proc_en && q_in_hdr) begin
      if (proc_idx < 3'd4) begin
        if (rd_data_r != pic_sig_byte(proc_idx[1:0])) begin
          ok_r <= 1'b0;
        end
      end else if (!proc_idx[0]) begin
        magic_r[7:0] <= rd_data_r;
      end else begin
        magic_r[15:8] <= rd_data_r;
      end
    end
  end

  assign res.done   = act_r && (cnt_r == LK_LAST_STEP);
  assign res.sig_ok = ok_r;
  assign res.magic  = magic_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !act_r)
    else $error("lookup restarted while busy");

  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    res.done |=> !act_r)
    else $error("lookup still active after done");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    act_r |-> !wr.en)
    else $error("header store written during lookup");

endmodule

`default_nettype wire
